[src/vtp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and helpers for the vertex transform pipeline.
// No dependencies.
package vtp_pkg;

  localparam int CW  = 32;           // coordinate and matrix entry width
  localparam int PW  = 64;           // full product width
  localparam int AW  = 66;           // sum of three products
  localparam int SW  = 51;           // column result after shift and translate
  localparam int NW  = 51;           // divider operand magnitude width
  localparam int FB  = 16;           // fraction bits
  localparam int QW  = 32;           // quotient bits developed by the divider
  localparam int NREG = 8;

  localparam logic [1:0] MODE_HOMOG  = 2'd0;
  localparam logic [1:0] MODE_PERSP  = 2'd1;
  localparam logic [1:0] MODE_NORMAL = 2'd2;

  localparam logic [63:0] MAT_RESET [NREG] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  // Sideband that rides alongside the divider lanes
  typedef struct packed {
    logic [1:0]            mode;
    logic [2:0]            neg;
    logic                  degen;
    logic [3:0][CW-1:0]    val;
    logic                  sat;
  } side_t;

  // Clamp to int32; bit 32 of the result flags a clamp
  function automatic logic [CW:0] sat32(input logic signed [SW-1:0] v);
    logic [CW:0] r;
    if (v > $signed({{(SW-CW){1'b0}}, 1'b0, {(CW-1){1'b1}}}))
      r = {1'b1, 1'b0, {(CW-1){1'b1}}};
    else if (v < $signed({{(SW-CW){1'b1}}, 1'b1, {(CW-1){1'b0}}}))
      r = {1'b1, 1'b1, {(CW-1){1'b0}}};
    else
      r = {1'b0, v[CW-1:0]};
    return r;
  endfunction

endpackage

[src/vertex_transform_perspective.sv]
`timescale 1ns / 1ps
// Vertex transform: 4x4 Q16.16 matrix multiply with optional perspective
// divide. Top level; depends on vtp_pkg and vtp_div.
//
// Usage:
//   Input beats (req_type, in_x, in_y, in_z) move on in_valid/in_ready,
//   results (out_x..out_w, degenerate, saturated) on out_valid/out_ready.
//   The matrix is written through cfg_we/cfg_index/cfg_data, one 64-bit
//   register per write, only while no beat is in flight.
//   Pipeline stages are multiply, sum, translate, prepare, 33 divider
//   stages (set-up, then one quotient bit per stage in three lanes) and
//   the output register. Every mode takes the same path, so results
//   leave in order. Throughput is one beat per clock; a new beat may enter
//   each cycle while the output is not held. When the receiver holds
//   out_ready low with a result waiting, the whole pipeline holds and
//   in_ready is low, bubbles included; in every other cycle it is high.
//   Synchronous reset clears all valid bits and sets the matrix to
//   identity.
module vertex_transform_perspective (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic signed [31:0]  out_w,
  output logic                degenerate,
  output logic                saturated,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  localparam int CW = vtp_pkg::CW;
  localparam int PW = vtp_pkg::PW;
  localparam int AW = vtp_pkg::AW;
  localparam int SW = vtp_pkg::SW;
  localparam int NW = vtp_pkg::NW;
  localparam int QW = vtp_pkg::QW;
  localparam int FB = vtp_pkg::FB;
  localparam int DL = QW + 1;        // divider depth

  logic en;
  logic [63:0] mat [vtp_pkg::NREG];
  logic signed [CW-1:0] ent [4][4];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vtp_pkg::NREG; i++) mat[i] <= vtp_pkg::MAT_RESET[i];
    end else if (cfg_we) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      ent[r][0] = mat[2*r][31:0];
      ent[r][1] = mat[2*r][63:32];
      ent[r][2] = mat[2*r+1][31:0];
      ent[r][3] = mat[2*r+1][63:32];
    end
  end

  // Stage 1: twelve products
  logic v1;
  logic [1:0] m1;
  logic signed [PW-1:0] p1 [3][4];
  logic signed [CW-1:0] vin [3];
  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= req_type;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 4; c++) p1[r][c] <= vin[r] * ent[r][c];
    end
  end

  // Stage 2: full-width column sums
  logic v2;
  logic [1:0] m2;
  logic signed [AW-1:0] sum2 [4];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m2 <= m1;
      for (int c = 0; c < 4; c++)
        sum2[c] <= AW'(p1[0][c]) + AW'(p1[1][c]) + AW'(p1[2][c]);
    end
  end

  // Stage 3: floor shift and translation for points
  logic v3;
  logic [1:0] m3;
  logic signed [SW-1:0] s3 [4];
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m3 <= m2;
      for (int c = 0; c < 4; c++)
        s3[c] <= SW'(sum2[c] >>> FB) +
                 ((m2 == vtp_pkg::MODE_NORMAL) ? SW'(0) : SW'(ent[3][c]));
    end
  end

  // Stage 4: saturate direct results, split divide into signs and magnitudes
  logic v4;
  vtp_pkg::side_t sd4;
  logic [NW-1:0] num4 [3];
  logic [NW-1:0] den4;
  logic [CW:0] cl [4];
  vtp_pkg::side_t sd_next;

  always_comb begin
    for (int c = 0; c < 4; c++) cl[c] = vtp_pkg::sat32(s3[c]);
    sd_next       = '0;
    sd_next.mode  = m3;
    sd_next.degen = (m3 == vtp_pkg::MODE_PERSP) && (s3[3] == '0);
    for (int j = 0; j < 3; j++) sd_next.neg[j] = s3[j][SW-1] ^ s3[3][SW-1];
    case (m3)
      vtp_pkg::MODE_HOMOG: begin
        for (int c = 0; c < 4; c++) sd_next.val[c] = cl[c][CW-1:0];
        sd_next.sat = cl[0][CW] | cl[1][CW] | cl[2][CW] | cl[3][CW];
      end
      vtp_pkg::MODE_NORMAL: begin
        for (int c = 0; c < 3; c++) sd_next.val[c] = cl[c][CW-1:0];
        sd_next.sat = cl[0][CW] | cl[1][CW] | cl[2][CW];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd4 <= sd_next;
      for (int j = 0; j < 3; j++)
        num4[j] <= s3[j][SW-1] ? NW'(-s3[j]) : NW'(s3[j]);
      den4 <= (s3[3] == '0) ? NW'(1) : (s3[3][SW-1] ? NW'(-s3[3]) : NW'(s3[3]));
    end
  end

  // Divider lanes
  logic [QW-1:0] quo [3];
  logic          ovf [3];
  for (genvar j = 0; j < 3; j++) begin : g_lane
    vtp_div u_div (
      .clk (clk),
      .en  (en),
      .num (num4[j]),
      .den (den4),
      .quo (quo[j]),
      .ovf (ovf[j])
    );
  end

  // Sideband delay matching the divider depth
  logic           dvld [DL];
  vtp_pkg::side_t dsd  [DL];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DL; i++) dvld[i] <= 1'b0;
    end else if (en) begin
      dvld[0] <= v4;
      for (int i = 1; i < DL; i++) dvld[i] <= dvld[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dsd[0] <= sd4;
      for (int i = 1; i < DL; i++) dsd[i] <= dsd[i-1];
    end
  end

  // Final: sign and clamp quotients, pick per mode
  vtp_pkg::side_t fs;
  logic [CW-1:0] qo [3];
  logic [2:0]    qs;
  logic [CW-1:0] ox_next, oy_next, oz_next, ow_next;
  logic          dg_next, st_next;

  assign fs = dsd[DL-1];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (fs.neg[j]) begin
        qs[j] = ovf[j] || (quo[j] > {1'b1, {(QW-1){1'b0}}});
        qo[j] = qs[j] ? {1'b1, {(CW-1){1'b0}}} : CW'(-quo[j]);
      end else begin
        qs[j] = ovf[j] || quo[j][QW-1];
        qo[j] = qs[j] ? {1'b0, {(CW-1){1'b1}}} : quo[j];
      end
    end
    ox_next = fs.val[0];
    oy_next = fs.val[1];
    oz_next = fs.val[2];
    ow_next = fs.val[3];
    dg_next = 1'b0;
    st_next = fs.sat;
    if (fs.mode == vtp_pkg::MODE_PERSP) begin
      ow_next = '0;
      if (fs.degen) begin
        ox_next = '0;
        oy_next = '0;
        oz_next = '0;
        dg_next = 1'b1;
        st_next = 1'b0;
      end else begin
        ox_next = qo[0];
        oy_next = qo[1];
        oz_next = qo[2];
        st_next = |qs;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dvld[DL-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_x      <= ox_next;
      out_y      <= oy_next;
      out_z      <= oz_next;
      out_w      <= ow_next;
      degenerate <= dg_next;
      saturated  <= st_next;
    end
  end

`ifndef SYNTHESIS
  a_ready_follows_output: assert property (@(posedge clk)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track the output register");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !saturated && out_x == 0 && out_y == 0
                                 && out_z == 0 && out_w == 0)
    else $error("degenerate beat carries data");
`endif

endmodule

[src/vtp_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider lane: one quotient bit per stage.
// Depends on vtp_pkg.
module vtp_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vtp_pkg::NW-1:0]    num,
  input  logic [vtp_pkg::NW-1:0]    den,
  output logic [vtp_pkg::QW-1:0]    quo,
  output logic                      ovf
);

  localparam int NW = vtp_pkg::NW;
  localparam int QW = vtp_pkg::QW;
  localparam int FB = vtp_pkg::FB;

  logic [NW-1:0] rem  [QW+1];
  logic [NW-1:0] dv   [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [QW-1:0] qv   [QW+1];
  logic          of   [QW+1];

  // Set up: quotient beyond 32 bits when num >= den * 2^16
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num >> FB;
      dv[0]  <= den;
      low[0] <= {num[FB-1:0], {(QW-FB){1'b0}}};
      qv[0]  <= '0;
      of[0]  <= ({{FB{1'b0}}, num} >= {den, {FB{1'b0}}});
    end
  end

  // Develop one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [NW:0] trial;
    logic        take;
    assign trial = {rem[i], low[i][QW-1]};
    assign take  = (trial >= {1'b0, dv[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? NW'(trial - {1'b0, dv[i]}) : trial[NW-1:0];
        dv[i+1]  <= dv[i];
        low[i+1] <= {low[i][QW-2:0], 1'b0};
        qv[i+1]  <= {qv[i][QW-2:0], take};
        of[i+1]  <= of[i];
      end
    end
  end

  assign quo = qv[QW];
  assign ovf = of[QW];

endmodule
